[rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion wrappers; compiled out when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// Clocked assertion, disabled while reset is held
`define ASSERT_RST(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Clocked assertion, always active
`define ASSERT_CLK(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_RST(lbl, clk, rst_n, prop, msg)
`define ASSERT_CLK(lbl, clk, prop, msg)
`endif

`endif

[rtl/dhti_pkg.sv]
// ----------------------------------------------------------------------------
// dhti_pkg
// Shared widths, codes and the slot row type of the double-hash table.
// ----------------------------------------------------------------------------
package dhti_pkg;

  localparam int unsigned KEY_W    = 31;
  localparam int unsigned AGE_W    = 8;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned SLOT_W   = 4;

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_LOOKUP = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_INSERTED  = 3'd0,
    ST_DUPLICATE = 3'd1,
    ST_FULL      = 3'd2,
    ST_FOUND     = 3'd3,
    ST_NOT_FOUND = 3'd4
  } status_e;

  typedef struct packed {
    logic             valid;
    logic [KEY_W-1:0] key;
    logic [AGE_W-1:0] age;
  } row_t;

endpackage

[rtl/dhti_divider.sv]
// ----------------------------------------------------------------------------
// dhti_divider
// Divide by the constant table size: reciprocal multiply for the quotient,
// then multiply-subtract for the remainder. Both valid while done_o is high;
// done_o follows start_i through the mul, sub and done registers.
// ----------------------------------------------------------------------------
module dhti_divider #(
  parameter int unsigned TABLE_SIZE = 11
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [dhti_pkg::KEY_W-1:0] dividend_i,
  output logic                       done_o,
  output logic [dhti_pkg::KEY_W-1:0] quotient_o,
  output logic [$clog2(TABLE_SIZE)-1:0] remainder_o
);

  localparam int unsigned IDX_W  = $clog2(TABLE_SIZE);
  localparam int unsigned SHIFT  = dhti_pkg::KEY_W + IDX_W;
  localparam int unsigned PROD_W = 2 * dhti_pkg::KEY_W + 1;
  // ceil(2^SHIFT / size): exact quotient for any 31-bit dividend, fits in 32 bits
  localparam logic [63:0] RECIP_FULL =
    ((64'd1 << SHIFT) + 64'(TABLE_SIZE) - 64'd1) / 64'(TABLE_SIZE);
  localparam logic [dhti_pkg::KEY_W:0]   RECIP   = RECIP_FULL[dhti_pkg::KEY_W:0];
  localparam logic [dhti_pkg::KEY_W-1:0] DIVISOR = dhti_pkg::KEY_W'(TABLE_SIZE);

  logic [dhti_pkg::KEY_W-1:0] dvd_q;
  logic [dhti_pkg::KEY_W-1:0] quot_q, quot_d;
  logic [IDX_W-1:0]           rem_q, rem_d;
  logic                       mul_q, sub_q, done_q;
  logic [PROD_W-1:0]          prod;
  logic [dhti_pkg::KEY_W-1:0] back, diff;

  // remainder is below the divisor, so its low bits are all that matter
  always_comb begin
    prod   = PROD_W'(dvd_q) * PROD_W'(RECIP);
    quot_d = dhti_pkg::KEY_W'(prod >> SHIFT);
    back   = quot_q * DIVISOR;
    diff   = dvd_q - back;
    rem_d  = diff[IDX_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mul_q  <= 1'b0;
      sub_q  <= 1'b0;
      done_q <= 1'b0;
      dvd_q  <= '0;
      quot_q <= '0;
      rem_q  <= '0;
    end else begin
      mul_q  <= start_i;
      sub_q  <= mul_q;
      done_q <= sub_q;
      if (start_i) begin
        dvd_q <= dividend_i;
      end
      if (mul_q) begin
        quot_q <= quot_d;
      end
      if (sub_q) begin
        rem_q <= rem_d;
      end
    end
  end

  assign done_o      = done_q;
  assign quotient_o  = quot_q;
  assign remainder_o = rem_q;

endmodule

[rtl/dhti_table.sv]
// ----------------------------------------------------------------------------
// dhti_table
// Slot memory, one read and one write port, registered read data.
// Sweeps every row to empty after reset.
// ----------------------------------------------------------------------------
module dhti_table #(
  parameter int unsigned TABLE_SIZE = 11
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          rd_en_i,
  input  logic [$clog2(TABLE_SIZE)-1:0] rd_addr_i,
  output dhti_pkg::row_t                rd_row_o,
  input  logic                          wr_en_i,
  input  logic [$clog2(TABLE_SIZE)-1:0] wr_addr_i,
  input  dhti_pkg::row_t                wr_row_i,
  output logic                          clr_busy_o
);

  localparam int unsigned IDX_W = $clog2(TABLE_SIZE);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_SIZE - 1);

  dhti_pkg::row_t   mem [TABLE_SIZE];
  dhti_pkg::row_t   rd_row_q;
  logic             clr_busy_q;
  logic [IDX_W-1:0] clr_idx_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_idx_q  <= '0;
    end else if (clr_busy_q) begin
      clr_idx_q <= clr_idx_q + 1'b1;
      if (clr_idx_q == LAST_IDX) begin
        clr_busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (clr_busy_q) begin
      mem[clr_idx_q] <= '0;
    end else if (wr_en_i) begin
      mem[wr_addr_i] <= wr_row_i;
    end
    if (rd_en_i) begin
      rd_row_q <= mem[rd_addr_i];
    end
  end

  assign rd_row_o   = rd_row_q;
  assign clr_busy_o = clr_busy_q;

endmodule

[rtl/double_hash_table_insert_lookup.sv]
// ----------------------------------------------------------------------------
// double_hash_table_insert_lookup
// Open-addressed hash table with double hashing: insert and look up.
// ----------------------------------------------------------------------------
// Input channel (in_valid_i/in_ready_o) carries command, key and age; one
// result (status, slot, found_age) leaves on out_valid_o/out_ready_i for each
// input transfer. in_ready_o stays low while an item is being worked on.
// Probe start and step come from a shared divide-by-TABLE_SIZE unit
// (reciprocal multiply, then multiply-subtract), run once for key mod/div
// TABLE_SIZE and once more for the step mod TABLE_SIZE (skipped when the
// quotient is zero).
// Each probe is a slot memory read, then the compare.
// An item makes 1 to TABLE_SIZE probes.
// The next item is taken once the result sits in the output register; if the
// receiver stalls, a second result waits inside until the first transfers.
// After reset the slot memory is swept empty, one row a cycle, with
// in_ready_o low.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module double_hash_table_insert_lookup #(
  parameter int unsigned TABLE_SIZE = 11
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          command_i,
  input  logic [dhti_pkg::KEY_W-1:0]    key_i,
  input  logic [dhti_pkg::AGE_W-1:0]    age_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [dhti_pkg::STATUS_W-1:0] status_o,
  output logic [dhti_pkg::SLOT_W-1:0]   slot_o,
  output logic [dhti_pkg::AGE_W-1:0]    found_age_o
);

  localparam int unsigned IDX_W = $clog2(TABLE_SIZE);
  localparam logic [IDX_W:0]   SIZE_X   = (IDX_W+1)'(TABLE_SIZE);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_SIZE - 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV1,
    S_DIV2,
    S_RD,
    S_CHK,
    S_DONE
  } state_e;

  state_e                        state_q, state_d;
  logic                          cmd_q, cmd_d;
  logic [dhti_pkg::KEY_W-1:0]    key_q, key_d;
  logic [dhti_pkg::AGE_W-1:0]    age_q, age_d;
  logic [IDX_W-1:0]              pos_q, pos_d;
  logic [IDX_W-1:0]              step_q, step_d;
  logic [IDX_W-1:0]              cnt_q, cnt_d;
  dhti_pkg::status_e             res_status_q, res_status_d;
  logic [dhti_pkg::SLOT_W-1:0]   res_slot_q, res_slot_d;
  logic [dhti_pkg::AGE_W-1:0]    res_age_q, res_age_d;
  logic                          out_valid_q, out_valid_d;
  dhti_pkg::status_e             out_status_q, out_status_d;
  logic [dhti_pkg::SLOT_W-1:0]   out_slot_q, out_slot_d;
  logic [dhti_pkg::AGE_W-1:0]    out_age_q, out_age_d;

  logic                          accept;
  logic                          div_start, div_done;
  logic [dhti_pkg::KEY_W-1:0]    div_dividend, div_quot;
  logic [IDX_W-1:0]              div_rem;
  dhti_pkg::row_t                rd_row, wr_row;
  logic                          wr_en, clr_busy;
  logic [IDX_W:0]                pos_sum;
  logic [IDX_W-1:0]              pos_next;

  assign in_ready_o = (state_q == S_IDLE) && !clr_busy;
  assign accept     = in_valid_i && in_ready_o;

  assign div_start    = accept || ((state_q == S_DIV1) && div_done && (div_quot != '0));
  assign div_dividend = (state_q == S_IDLE) ? key_i : div_quot;

  dhti_divider #(
    .TABLE_SIZE (TABLE_SIZE)
  ) u_divider (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (div_start),
    .dividend_i  (div_dividend),
    .done_o      (div_done),
    .quotient_o  (div_quot),
    .remainder_o (div_rem)
  );

  // insert into an empty slot is written back in the compare cycle
  assign wr_en = (state_q == S_CHK) && !rd_row.valid && (cmd_q == dhti_pkg::CMD_INSERT);
  always_comb begin
    wr_row.valid = 1'b1;
    wr_row.key   = key_q;
    wr_row.age   = age_q;
  end

  dhti_table #(
    .TABLE_SIZE (TABLE_SIZE)
  ) u_table (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rd_en_i    (state_q == S_RD),
    .rd_addr_i  (pos_q),
    .rd_row_o   (rd_row),
    .wr_en_i    (wr_en),
    .wr_addr_i  (pos_q),
    .wr_row_i   (wr_row),
    .clr_busy_o (clr_busy)
  );

  // next probe: both terms below the size, so one conditional subtract
  always_comb begin
    pos_sum  = {1'b0, pos_q} + {1'b0, step_q};
    pos_next = (pos_sum >= SIZE_X) ? IDX_W'(pos_sum - SIZE_X) : pos_sum[IDX_W-1:0];
  end

  always_comb begin
    state_d      = state_q;
    cmd_d        = cmd_q;
    key_d        = key_q;
    age_d        = age_q;
    pos_d        = pos_q;
    step_d       = step_q;
    cnt_d        = cnt_q;
    res_status_d = res_status_q;
    res_slot_d   = res_slot_q;
    res_age_d    = res_age_q;
    out_valid_d  = out_valid_q;
    out_status_d = out_status_q;
    out_slot_d   = out_slot_q;
    out_age_d    = out_age_q;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          cmd_d   = command_i;
          key_d   = key_i;
          age_d   = age_i;
          state_d = S_DIV1;
        end
      end
      S_DIV1: begin
        if (div_done) begin
          pos_d = div_rem;
          cnt_d = '0;
          if (div_quot == '0) begin
            step_d  = IDX_W'(1);
            state_d = S_RD;
          end else begin
            state_d = S_DIV2;
          end
        end
      end
      S_DIV2: begin
        if (div_done) begin
          step_d  = div_rem;
          state_d = S_RD;
        end
      end
      S_RD: begin
        state_d = S_CHK;
      end
      S_CHK: begin
        res_slot_d = dhti_pkg::SLOT_W'(pos_q);
        res_age_d  = '0;
        state_d    = S_DONE;
        if (!rd_row.valid) begin
          if (cmd_q == dhti_pkg::CMD_INSERT) begin
            res_status_d = dhti_pkg::ST_INSERTED;
          end else begin
            res_status_d = dhti_pkg::ST_NOT_FOUND;
            res_slot_d   = '0;
          end
        end else if (rd_row.key == key_q) begin
          if (cmd_q == dhti_pkg::CMD_INSERT) begin
            res_status_d = dhti_pkg::ST_DUPLICATE;
          end else begin
            res_status_d = dhti_pkg::ST_FOUND;
            res_age_d    = rd_row.age;
          end
        end else if (cnt_q == LAST_IDX) begin
          res_slot_d   = '0;
          res_status_d = (cmd_q == dhti_pkg::CMD_INSERT) ? dhti_pkg::ST_FULL
                                                         : dhti_pkg::ST_NOT_FOUND;
        end else begin
          cnt_d   = cnt_q + 1'b1;
          pos_d   = pos_next;
          state_d = S_RD;
        end
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d  = 1'b1;
          out_status_d = res_status_q;
          out_slot_d   = res_slot_q;
          out_age_d    = res_age_q;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      cmd_q        <= dhti_pkg::CMD_INSERT;
      key_q        <= '0;
      age_q        <= '0;
      pos_q        <= '0;
      step_q       <= '0;
      cnt_q        <= '0;
      res_status_q <= dhti_pkg::ST_INSERTED;
      res_slot_q   <= '0;
      res_age_q    <= '0;
      out_valid_q  <= 1'b0;
      out_status_q <= dhti_pkg::ST_INSERTED;
      out_slot_q   <= '0;
      out_age_q    <= '0;
    end else begin
      state_q      <= state_d;
      cmd_q        <= cmd_d;
      key_q        <= key_d;
      age_q        <= age_d;
      pos_q        <= pos_d;
      step_q       <= step_d;
      cnt_q        <= cnt_d;
      res_status_q <= res_status_d;
      res_slot_q   <= res_slot_d;
      res_age_q    <= res_age_d;
      out_valid_q  <= out_valid_d;
      out_status_q <= out_status_d;
      out_slot_q   <= out_slot_d;
      out_age_q    <= out_age_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = out_status_q;
  assign slot_o      = out_slot_q;
  assign found_age_o = out_age_q;

  `ASSERT_RST(a_busy_after_accept, clk_i, rst_ni, accept |=> !in_ready_o, "ready after transfer")
  `ASSERT_RST(a_pos_in_range, clk_i, rst_ni, (state_q == S_RD || state_q == S_CHK) |-> (pos_q <= LAST_IDX), "probe slot out of range")
  `ASSERT_RST(a_div_done_state, clk_i, rst_ni, div_done |-> (state_q == S_DIV1 || state_q == S_DIV2), "divider result unexpected")
  `ASSERT_RST(a_result_from_done, clk_i, rst_ni, $rose(out_valid_q) |-> $past(state_q == S_DONE), "result without finished probe")

endmodule
